FILE: hw/rtl/assert_macros.svh
// Concurrent assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every rising clock edge out of reset.
`define BRB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Expression must never be true out of reset.
`define BRB_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
    else $error("forbidden condition seen");

`else

`define BRB_ASSERT(lbl, clk, rst_n, prop)
`define BRB_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

FILE: hw/rtl/brb_pkg.sv
// Types and constants of the byte ring buffer.
package brb_pkg;

  localparam int unsigned DEPTH      = 1024;
  localparam int unsigned MAX_BYTES  = 8;
  localparam int unsigned NUM_BANKS  = 8;
  localparam int unsigned BANK_W     = $clog2(NUM_BANKS);
  localparam int unsigned PTR_W      = $clog2(DEPTH);
  localparam int unsigned ROW_W      = PTR_W - BANK_W;
  localparam int unsigned BANK_DEPTH = DEPTH / NUM_BANKS;
  localparam int unsigned CMP_W      = PTR_W + 1;
  localparam int unsigned FILL_W     = 10;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [1:0] ST_DONE       = 2'd0;
  localparam logic [1:0] ST_ZERO_WRITE = 2'd1;
  localparam logic [1:0] ST_REFUSED    = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [3:0]  byte_count;
    logic [63:0] write_bytes;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [3:0]        done_count;
    logic [63:0]       read_bytes;
    logic [FILL_W-1:0] fill_level;
  } rsp_t;

  typedef struct packed {
    logic load_req;
    logic exec;
    logic load_rsp;
  } cmd_t;

endpackage

FILE: hw/rtl/brb_ram.sv
// Generic single-port RAM with registered read.
module brb_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/brb_ctrl.sv
// Sequencing controller and output handshake of the byte ring buffer.
module brb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output brb_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o.load_req = (state_q == S_IDLE) && in_valid_i;
    cmd_o.exec     = (state_q == S_EXEC);
    cmd_o.load_rsp = (state_q == S_FINISH) && out_free;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output register can take the transaction
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: hw/rtl/brb_dp.sv
// Datapath: pointers, byte banks, access checks and result register.
module brb_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  brb_pkg::cmd_t cmd_i,
  input  brb_pkg::req_t req_i,
  output brb_pkg::rsp_t rsp_o
);

  localparam int unsigned NB = brb_pkg::NUM_BANKS;
  localparam int unsigned BW = brb_pkg::BANK_W;
  localparam int unsigned PW = brb_pkg::PTR_W;
  localparam int unsigned CW = brb_pkg::CMP_W;

  brb_pkg::req_t req_q;
  brb_pkg::rsp_t rsp_q, rsp_d;

  logic [PW-1:0] wp_q, wp_d;
  logic [PW-1:0] rp_q, rp_d;
  logic [1:0]    status_q, status_d;
  logic [3:0]    done_q, done_d;
  logic          rd_flag_q, rd_flag_d;
  logic [BW-1:0] rot_q;

  logic [PW-1:0] fill_now, free_now;
  logic          cnt_zero, cnt_big, space_short, data_short;
  logic          wr_ok, rd_ok;

  logic [7:0]                   bank_wdata [NB];
  logic [7:0]                   bank_rdata [NB];
  logic [brb_pkg::ROW_W-1:0]    bank_row   [NB];
  logic [NB-1:0]                bank_we, bank_re;

  // access checks against the current pointers
  always_comb begin
    fill_now    = wp_q - rp_q;
    free_now    = ~fill_now;
    cnt_zero    = (req_q.byte_count == 4'd0);
    cnt_big     = (req_q.byte_count > 4'(brb_pkg::MAX_BYTES));
    space_short = ({1'b0, free_now} < CW'(req_q.byte_count));
    data_short  = ({1'b0, fill_now} < CW'(req_q.byte_count));
    wr_ok = cmd_i.exec && (req_q.opcode == brb_pkg::OP_WRITE) &&
            !cnt_zero && !cnt_big && !space_short;
    rd_ok = cmd_i.exec && (req_q.opcode == brb_pkg::OP_READ) &&
            !cnt_zero && !cnt_big && !data_short;

    status_d = brb_pkg::ST_DONE;
    if (req_q.opcode == brb_pkg::OP_WRITE && cnt_zero) begin
      status_d = brb_pkg::ST_ZERO_WRITE;
    end else if (!cnt_zero && !wr_ok && !rd_ok) begin
      status_d = brb_pkg::ST_REFUSED;
    end

    done_d    = (wr_ok || rd_ok) ? req_q.byte_count : 4'd0;
    rd_flag_d = rd_ok;
    wp_d      = wr_ok ? wp_q + PW'(req_q.byte_count) : wp_q;
    rp_d      = rd_ok ? rp_q + PW'(req_q.byte_count) : rp_q;
  end

  // map byte lanes onto banks: byte i sits at address ptr + i
  always_comb begin
    logic [BW-1:0] wofs, rofs;
    logic [PW-1:0] waddr, raddr;
    for (int b = 0; b < NB; b++) begin
      wofs  = BW'(b) - wp_q[BW-1:0];
      rofs  = BW'(b) - rp_q[BW-1:0];
      waddr = wp_q + PW'(wofs);
      raddr = rp_q + PW'(rofs);
      bank_we[b]    = wr_ok && ({1'b0, wofs} < req_q.byte_count);
      bank_re[b]    = rd_ok && ({1'b0, rofs} < req_q.byte_count);
      bank_wdata[b] = req_q.write_bytes[8*wofs +: 8];
      bank_row[b]   = wr_ok ? waddr[PW-1:BW] : raddr[PW-1:BW];
    end
  end

  for (genvar g = 0; g < NB; g++) begin : g_bank
    brb_ram #(
      .DATA_W (8),
      .DEPTH  (brb_pkg::BANK_DEPTH)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we[g]),
      .re_i    (bank_re[g]),
      .addr_i  (bank_row[g]),
      .wdata_i (bank_wdata[g]),
      .rdata_o (bank_rdata[g])
    );
  end

  // rotate bank data back into byte order and drop unused lanes
  always_comb begin
    logic [BW-1:0] idx;
    rsp_d.status     = status_q;
    rsp_d.done_count = done_q;
    rsp_d.fill_level = brb_pkg::FILL_W'(wp_q - rp_q);
    rsp_d.read_bytes = '0;
    for (int i = 0; i < NB; i++) begin
      idx = rot_q + BW'(i);
      if (rd_flag_q && (4'(i) < done_q)) begin
        rsp_d.read_bytes[8*i +: 8] = bank_rdata[idx];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
    end else if (cmd_i.exec) begin
      wp_q <= wp_d;
      rp_q <= rp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= req_i;
    end
    if (cmd_i.exec) begin
      status_q  <= status_d;
      done_q    <= done_d;
      rd_flag_q <= rd_flag_d;
      rot_q     <= rp_q[BW-1:0];
    end
    if (cmd_i.load_rsp) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

FILE: hw/rtl/byte_ring_buffer_block_io.sv
// Byte ring buffer: top level joining controller and datapath.
// A byte FIFO of DEPTH-1 usable bytes held in eight byte-wide banks, each access
// a write or read of up to eight packed bytes, all or nothing. An access first
// registers the request, then checks it and drives the banks, then rotates the
// registered bank read into byte order, holding until the output register is
// free to load it. A new access is taken while the previous result
// still waits at the output register; the result is held there until taken.
// Memory content is undefined after reset; only bytes that were written are read.
`include "assert_macros.svh"

module byte_ring_buffer_block_io (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  brb_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output brb_pkg::rsp_t out_data_o
);

  brb_pkg::cmd_t cmd;
  logic          rsp_refused;
  logic          rsp_empty;

  brb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  brb_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (in_data_i),
    .rsp_o  (out_data_o)
  );

  assign rsp_refused = out_valid_o && (out_data_o.status != brb_pkg::ST_DONE);
  assign rsp_empty   = (out_data_o.done_count == 4'd0) && (out_data_o.read_bytes == 64'd0);

  `BRB_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o)
  `BRB_NEVER(a_cmd_overlap, clk_i, rst_ni, cmd.load_req && (cmd.exec || cmd.load_rsp))
  `BRB_ASSERT(a_refused_empty, clk_i, rst_ni, rsp_refused |-> rsp_empty)

endmodule

FILE: tb/byte_ring_buffer_block_io_test.sv
// Testbench of the byte ring buffer: random and directed accesses checked against a ring model.
`timescale 1ns / 1ps

module byte_ring_buffer_block_io_test;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned SHOW_LIMIT  = 10;

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  brb_pkg::req_t in_data_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  brb_pkg::rsp_t out_data_o;

  byte_ring_buffer_block_io u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Ring model state
  logic [7:0]                ring_mem [brb_pkg::DEPTH];
  logic [brb_pkg::PTR_W-1:0] wr_ptr = '0;
  logic [brb_pkg::PTR_W-1:0] rd_ptr = '0;

  brb_pkg::req_t req_queue [$];
  brb_pkg::rsp_t rsp_due [$];
  int unsigned   items_sent = 0;
  int unsigned   rsp_seen   = 0;
  int unsigned   bad_rsp    = 0;
  int unsigned   quiet      = 0;
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;
  logic          req_fire = 1'b0;

  // Stimulus-side view of the fill level, used only to steer the random mix
  int unsigned gen_fill    = 0;
  logic        gen_filling = 1'b1;
  int unsigned gen_refused = 0;

  function automatic brb_pkg::rsp_t ring_access(brb_pkg::req_t req);
    brb_pkg::rsp_t             rsp;
    logic [brb_pkg::PTR_W-1:0] fill;
    int unsigned               cnt;
    rsp  = '0;
    cnt  = req.byte_count;
    fill = wr_ptr - rd_ptr;
    rsp.status = brb_pkg::ST_DONE;
    if (req.opcode == brb_pkg::OP_WRITE) begin
      if (cnt == 0) begin
        rsp.status = brb_pkg::ST_ZERO_WRITE;
      end else if (cnt > brb_pkg::MAX_BYTES || (brb_pkg::DEPTH - 1 - fill) < cnt) begin
        rsp.status = brb_pkg::ST_REFUSED;
      end else begin
        for (int i = 0; i < cnt; i++) begin
          ring_mem[wr_ptr + brb_pkg::PTR_W'(i)] = req.write_bytes[8*i +: 8];
        end
        wr_ptr          = wr_ptr + brb_pkg::PTR_W'(cnt);
        rsp.done_count  = 4'(cnt);
      end
    end else if (cnt != 0) begin
      if (cnt > brb_pkg::MAX_BYTES || fill < cnt) begin
        rsp.status = brb_pkg::ST_REFUSED;
      end else begin
        for (int i = 0; i < cnt; i++) begin
          rsp.read_bytes[8*i +: 8] = ring_mem[rd_ptr + brb_pkg::PTR_W'(i)];
        end
        rd_ptr         = rd_ptr + brb_pkg::PTR_W'(cnt);
        rsp.done_count = 4'(cnt);
      end
    end
    rsp.fill_level = brb_pkg::FILL_W'(wr_ptr - rd_ptr);
    return rsp;
  endfunction

  // Queue one access; return whether it will go through
  function automatic logic push_access(logic op, int unsigned cnt, logic [63:0] data);
    brb_pkg::req_t req;
    logic          ok;
    req.opcode      = op;
    req.byte_count  = 4'(cnt);
    req.write_bytes = data;
    req_queue.push_back(req);
    items_sent++;
    ok = 1'b0;
    if (cnt >= 1 && cnt <= brb_pkg::MAX_BYTES) begin
      if (op == brb_pkg::OP_WRITE && cnt <= brb_pkg::DEPTH - 1 - gen_fill) begin
        gen_fill += cnt;
        ok = 1'b1;
      end else if (op == brb_pkg::OP_READ && cnt <= gen_fill) begin
        gen_fill -= cnt;
        ok = 1'b1;
      end
    end
    return ok;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic gen_random(int unsigned n);
    logic        op;
    int unsigned cnt;
    int unsigned pick;
    for (int k = 0; k < n; k++) begin
      op   = ($urandom_range(99) < 85) ?
             (gen_filling ? brb_pkg::OP_WRITE : brb_pkg::OP_READ) :
             (gen_filling ? brb_pkg::OP_READ : brb_pkg::OP_WRITE);
      pick = $urandom_range(99);
      if (pick < 6) cnt = 0;
      else if (pick < 12) cnt = $urandom_range(15, brb_pkg::MAX_BYTES + 1);
      else cnt = $urandom_range(brb_pkg::MAX_BYTES, 1);
      if (!push_access(op, cnt, rand_word()) && cnt >= 1 && cnt <= brb_pkg::MAX_BYTES &&
          (op == brb_pkg::OP_WRITE) == gen_filling) begin
        gen_refused++;
      end
      // Turn around once the ring is full or empty, or refusals pile up near the edge
      if (gen_filling ? (gen_fill == brb_pkg::DEPTH - 1) : (gen_fill == 0)) begin
        gen_filling = ~gen_filling;
        gen_refused = 0;
      end else if (gen_refused >= 16) begin
        gen_filling = ~gen_filling;
        gen_refused = 0;
      end
    end
  endtask

  task automatic wait_drained();
    while (rsp_seen < items_sent) @(negedge clk_i);
  endtask

  // Driver: hold the payload while stalled, advance after each transaction
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || req_fire) begin
      if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= req_queue.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Monitor: predict on each accepted request, check each accepted result
  always @(posedge clk_i) begin
    brb_pkg::rsp_t want;
    logic          in_fire;
    logic          out_fire;
    in_fire  = rst_ni && in_valid_i && !in_stall_o;
    out_fire = rst_ni && out_valid_o && !out_stall_i;
    req_fire <= in_fire;
    if (out_fire) begin
      rsp_seen <= rsp_seen + 1;
      if (rsp_due.size() == 0) begin
        bad_rsp++;
        if (bad_rsp <= SHOW_LIMIT)
          $display("unexpected result: status %0d count %0d bytes %h fill %0d",
                   out_data_o.status, out_data_o.done_count, out_data_o.read_bytes,
                   out_data_o.fill_level);
      end else begin
        want = rsp_due.pop_front();
        if (out_data_o.status !== want.status || out_data_o.done_count !== want.done_count ||
            out_data_o.read_bytes !== want.read_bytes ||
            out_data_o.fill_level !== want.fill_level) begin
          bad_rsp++;
          if (bad_rsp <= SHOW_LIMIT) begin
            $display("mismatch: expected status %0d count %0d bytes %h fill %0d",
                     want.status, want.done_count, want.read_bytes, want.fill_level);
            $display("          got      status %0d count %0d bytes %h fill %0d",
                     out_data_o.status, out_data_o.done_count, out_data_o.read_bytes,
                     out_data_o.fill_level);
          end
        end
      end
    end
    if (in_fire) rsp_due.push_back(ring_access(in_data_i));
    if (rst_ni) begin
      if (in_fire || out_fire) begin
        quiet <= 0;
      end else if (quiet + 1 >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    logic ok;
    rst_ni        = 1'b0;
    send_idle_pct = 14;
    recv_idle_pct = 56;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty ring, zero lengths and oversized counts
    ok = push_access(brb_pkg::OP_READ, 0, rand_word());
    ok = push_access(brb_pkg::OP_READ, 1, rand_word());
    ok = push_access(brb_pkg::OP_WRITE, 0, rand_word());
    ok = push_access(brb_pkg::OP_WRITE, brb_pkg::MAX_BYTES + 1, rand_word());
    ok = push_access(brb_pkg::OP_WRITE, 15, '1);
    ok = push_access(brb_pkg::OP_WRITE, brb_pkg::MAX_BYTES, '1);
    ok = push_access(brb_pkg::OP_WRITE, brb_pkg::MAX_BYTES, '0);
    for (int c = 1; c < brb_pkg::MAX_BYTES; c++) begin
      ok = push_access(brb_pkg::OP_WRITE, c, rand_word());
    end
    ok = push_access(brb_pkg::OP_READ, brb_pkg::MAX_BYTES + 1, rand_word());
    ok = push_access(brb_pkg::OP_READ, 15, '1);
    ok = push_access(brb_pkg::OP_READ, 0, '1);
    ok = push_access(brb_pkg::OP_READ, brb_pkg::MAX_BYTES, rand_word());
    ok = push_access(brb_pkg::OP_READ, brb_pkg::MAX_BYTES, rand_word());
    for (int c = 1; c < brb_pkg::MAX_BYTES; c++) begin
      ok = push_access(brb_pkg::OP_READ, c, rand_word());
    end
    // Drained: more data than stored
    ok = push_access(brb_pkg::OP_READ, 1, rand_word());
    wait_drained();

    gen_random(450);
    wait_drained();

    send_idle_pct = 56;
    recv_idle_pct = 14;
    gen_random(450);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    gen_random(450);
    wait_drained();

    repeat (10) @(negedge clk_i);
    if (bad_rsp == 0 && rsp_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/brb_pkg.sv
hw/rtl/brb_ram.sv
hw/rtl/brb_ctrl.sv
hw/rtl/brb_dp.sv
hw/rtl/byte_ring_buffer_block_io.sv
tb/byte_ring_buffer_block_io_test.sv
